// File: rtl/pwrt_pkg.sv
package pwrt_pkg;

    localparam int MAX_RANGES   = 16;
    localparam int PACKET_BYTES = 188;
    localparam int META_BYTES   = 16;

    localparam int RI_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int UC_W = $clog2(MAX_RANGES + 1);
    localparam int PB_W = $clog2(PACKET_BYTES + 1);

    // Slot division works on offsets below slots * PACKET_BYTES.
    localparam int D_W       = 16 + PB_W;
    localparam int DIV_SHIFT = D_W;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam longint unsigned RECIP_L = (64'd1 << DIV_SHIFT) / PACKET_BYTES;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    localparam int IN_W  = 144;
    localparam int OUT_W = 104;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [31:0] pbase;
        logic [31:0] mbase;
        logic [15:0] first;
        logic [15:0] length;
    } t_entry;

    typedef struct packed {
        logic [31:0] paddr;
        logic [31:0] buf_base;
        logic [15:0] slots;
    } t_slot_req;

    typedef struct packed {
        logic        valid;
        logic [15:0] slot;
    } t_slot_res;

endpackage

// File: rtl/pwrt_ram.sv
module pwrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pwrt_slot.sv
module pwrt_slot (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pwrt_pkg::t_slot_req  i_req,
    output logic                 o_done,
    output pwrt_pkg::t_slot_res  o_res
);

    localparam int D_W     = pwrt_pkg::D_W;
    localparam int RECIP_W = pwrt_pkg::RECIP_W;
    localparam int P_W     = D_W + RECIP_W;

    logic [3:0]       r_v;
    logic [31:0]      r1_d;
    logic             r1_inr;
    logic [D_W-1:0]   r1_lim;
    logic [D_W-1:0]   r2_d;
    logic             r2_ok;
    logic [15:0]      r2_qest;
    logic [D_W-1:0]   r3_d;
    logic             r3_ok;
    logic [15:0]      r3_qest;
    logic [D_W-1:0]   r3_prod;
    logic             r4_valid;
    logic [15:0]      r4_slot;
    logic [P_W-1:0]   w_qprod;
    logic [D_W-1:0]   w_rem;
    logic             w_exact;
    logic             w_next;

    assign w_qprod = P_W'(r1_d[D_W-1:0]) * P_W'(pwrt_pkg::RECIP);
    assign w_rem   = r3_d - r3_prod;
    assign w_exact = (w_rem == '0);
    assign w_next  = (w_rem == D_W'(pwrt_pkg::PACKET_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d     <= i_req.paddr - i_req.buf_base;
        r1_inr   <= (i_req.buf_base != '0) && (i_req.paddr >= i_req.buf_base);
        r1_lim   <= D_W'(i_req.slots) * D_W'(pwrt_pkg::PACKET_BYTES);
        r2_d     <= r1_d[D_W-1:0];
        r2_ok    <= r1_inr && (r1_d < 32'(r1_lim));
        r2_qest  <= w_qprod[pwrt_pkg::DIV_SHIFT +: 16];
        r3_d     <= r2_d;
        r3_ok    <= r2_ok;
        r3_qest  <= r2_qest;
        r3_prod  <= D_W'(r2_qest) * D_W'(pwrt_pkg::PACKET_BYTES);
        r4_valid <= r3_ok && (w_exact || w_next);
        if (r3_ok && w_exact) begin
            r4_slot <= r3_qest;
        end else if (r3_ok && w_next) begin
            r4_slot <= r3_qest + 16'd1;
        end else begin
            r4_slot <= '0;
        end
    end

    assign o_done      = r_v[3];
    assign o_res.valid = r4_valid;
    assign o_res.slot  = r4_slot;

endmodule

// File: rtl/packet_window_range_table.sv
// Range table for a window of fixed-size packets, driven by one command per transfer on the
// input stream (tuser: clear, append range or look up index) and answering each command with
// exactly one result transfer. The ranges live in a table memory with a registered read.
// Clear, an unused command, a lookup outside the window, an append that would overflow the
// window and an append to an empty table go straight to the result; any other append reads
// the last range, forms its end addresses, compares and writes, also when the table is full.
// A lookup reads the range where the walk from the last range used starts, reads one further
// range for each step of that walk, then forms the offset products and the addresses and runs
// the four-stage slot divider. A finished result waits in the output register, and a new
// command is taken once it is there.
module packet_window_range_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // index, range_count, packet_base, meta_base, buffer_base, buffer_slots
    input  logic [pwrt_pkg::IN_W-1:0] i_s_axis_tdata,
    // opcode
    input  logic [1:0]                i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // packet_addr, meta_addr, slot_index, slot_valid, window_size, zero fill
    output logic [pwrt_pkg::OUT_W-1:0] o_m_axis_tdata,
    // status
    output logic [1:0]                o_m_axis_tuser
);

    localparam int RI_W = pwrt_pkg::RI_W;
    localparam int UC_W = pwrt_pkg::UC_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_MUL  = 4'd1;
    localparam logic [3:0] S_A_CMP  = 4'd2;
    localparam logic [3:0] S_L_DN   = 4'd3;
    localparam logic [3:0] S_L_UP   = 4'd4;
    localparam logic [3:0] S_L_MUL  = 4'd5;
    localparam logic [3:0] S_L_ADD  = 4'd6;
    localparam logic [3:0] S_L_SLOT = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]      r_state, n_state;
    logic [UC_W-1:0] r_used, n_used;
    logic [15:0]     r_total, n_total;
    logic [RI_W-1:0] r_last, n_last;
    logic [RI_W-1:0] r_ri, n_ri;
    logic            r_out_valid, n_out_valid;

    logic [15:0] r_index, n_index;
    logic [15:0] r_count, n_count;
    logic [31:0] r_pb, n_pb;
    logic [31:0] r_mb, n_mb;
    logic [31:0] r_buf, n_buf;
    logic [15:0] r_slots, n_slots;
    logic [15:0] r_off, n_off;
    logic [31:0] r_pprod, n_pprod;
    logic [31:0] r_mprod, n_mprod;
    logic [1:0]  r_status, n_status;
    logic [31:0] r_paddr, n_paddr;
    logic [31:0] r_maddr, n_maddr;
    logic [15:0] r_slot, n_slot;
    logic        r_svalid, n_svalid;
    logic [1:0]  r_out_status, n_out_status;
    logic [31:0] r_out_pa, n_out_pa;
    logic [31:0] r_out_ma, n_out_ma;
    logic [15:0] r_out_slot, n_out_slot;
    logic        r_out_sv, n_out_sv;
    logic [15:0] r_out_ws, n_out_ws;

    logic                    w_we;
    logic [RI_W-1:0]         w_waddr;
    pwrt_pkg::t_entry        w_wdata;
    logic                    w_re;
    logic [RI_W-1:0]         w_raddr;
    logic [$bits(pwrt_pkg::t_entry)-1:0] w_rdata;
    pwrt_pkg::t_entry        w_q;
    logic                    w_slot_start;
    pwrt_pkg::t_slot_req     w_slot_req;
    logic                    w_slot_done;
    pwrt_pkg::t_slot_res     w_slot_res;

    logic [15:0]     w_in_index;
    logic [15:0]     w_in_count;
    logic [16:0]     w_sum;
    logic [RI_W-1:0] w_top;
    logic [RI_W-1:0] w_start_ri;
    logic [16:0]     w_end;
    logic            w_down;
    logic            w_up;
    logic            w_merge;
    logic [31:0]     w_paddr;

    assign w_in_index = i_s_axis_tdata[15:0];
    assign w_in_count = i_s_axis_tdata[31:16];
    assign w_sum      = {1'b0, r_total} + {1'b0, w_in_count};
    assign w_top      = RI_W'(r_used - UC_W'(1));
    assign w_start_ri = (w_in_index == '0) ? '0
                      : ((UC_W'(r_last) >= r_used) ? w_top : r_last);
    assign w_q        = pwrt_pkg::t_entry'(w_rdata);
    assign w_end      = {1'b0, w_q.first} + {1'b0, w_q.length};
    assign w_down     = (r_ri != '0) && (r_index < w_q.first);
    assign w_up       = (r_index != '0) && ((UC_W'(r_ri) + UC_W'(1)) < r_used)
                      && ({1'b0, r_index} >= w_end);
    assign w_merge    = (r_pb == w_q.pbase + r_pprod) && (r_mb == w_q.mbase + r_mprod);
    assign w_paddr    = w_q.pbase + r_pprod;

    assign w_slot_req.paddr    = w_paddr;
    assign w_slot_req.buf_base = r_buf;
    assign w_slot_req.slots    = r_slots;

    pwrt_ram #(
        .WIDTH ($bits(pwrt_pkg::t_entry)),
        .DEPTH (pwrt_pkg::MAX_RANGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pwrt_slot u_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_slot_start),
        .i_req   (w_slot_req),
        .o_done  (w_slot_done),
        .o_res   (w_slot_res)
    );

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_total      = r_total;
        n_last       = r_last;
        n_ri         = r_ri;
        n_out_valid  = r_out_valid;
        n_index      = r_index;
        n_count      = r_count;
        n_pb         = r_pb;
        n_mb         = r_mb;
        n_buf        = r_buf;
        n_slots      = r_slots;
        n_off        = r_off;
        n_pprod      = r_pprod;
        n_mprod      = r_mprod;
        n_status     = r_status;
        n_paddr      = r_paddr;
        n_maddr      = r_maddr;
        n_slot       = r_slot;
        n_svalid     = r_svalid;
        n_out_status = r_out_status;
        n_out_pa     = r_out_pa;
        n_out_ma     = r_out_ma;
        n_out_slot   = r_out_slot;
        n_out_sv     = r_out_sv;
        n_out_ws     = r_out_ws;
        w_we         = 1'b0;
        w_waddr      = RI_W'(r_used);
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = r_ri;
        w_slot_start = 1'b0;

        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_index  = w_in_index;
                    n_count  = w_in_count;
                    n_pb     = i_s_axis_tdata[63:32];
                    n_mb     = i_s_axis_tdata[95:64];
                    n_buf    = i_s_axis_tdata[127:96];
                    n_slots  = i_s_axis_tdata[143:128];
                    n_status = pwrt_pkg::ST_OK;
                    n_paddr  = '0;
                    n_maddr  = '0;
                    n_slot   = '0;
                    n_svalid = 1'b0;
                    n_state  = S_OUT;
                    unique case (i_s_axis_tuser)
                        pwrt_pkg::OP_CLEAR: begin
                            n_used  = '0;
                            n_total = '0;
                            n_last  = '0;
                        end
                        pwrt_pkg::OP_APPEND: begin
                            if (w_sum[16]) begin
                                n_status = pwrt_pkg::ST_OVERFLOW;
                            end else if (r_used == '0) begin
                                w_we          = 1'b1;
                                w_waddr       = '0;
                                w_wdata.pbase  = i_s_axis_tdata[63:32];
                                w_wdata.mbase  = i_s_axis_tdata[95:64];
                                w_wdata.first  = r_total;
                                w_wdata.length = w_in_count;
                                n_used        = UC_W'(1);
                                n_total       = w_sum[15:0];
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = w_top;
                                n_state = S_A_MUL;
                            end
                        end
                        pwrt_pkg::OP_LOOKUP: begin
                            if (w_in_index >= r_total || r_used == '0) begin
                                n_status = pwrt_pkg::ST_OUTSIDE;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = w_start_ri;
                                n_ri    = w_start_ri;
                                n_state = S_L_DN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_A_MUL: begin
                n_pprod = 32'(w_q.length) * 32'(pwrt_pkg::PACKET_BYTES);
                n_mprod = 32'(w_q.length) * 32'(pwrt_pkg::META_BYTES);
                n_state = S_A_CMP;
            end
            S_A_CMP: begin
                n_state = S_OUT;
                if (w_merge) begin
                    w_we           = 1'b1;
                    w_waddr        = w_top;
                    w_wdata        = w_q;
                    w_wdata.length = w_q.length + r_count;
                    n_total        = r_total + r_count;
                end else if (r_used == UC_W'(pwrt_pkg::MAX_RANGES)) begin
                    n_status = pwrt_pkg::ST_FULL;
                end else begin
                    w_we           = 1'b1;
                    w_waddr        = RI_W'(r_used);
                    w_wdata.pbase  = r_pb;
                    w_wdata.mbase  = r_mb;
                    w_wdata.first  = r_total;
                    w_wdata.length = r_count;
                    n_used         = r_used + UC_W'(1);
                    n_total        = r_total + r_count;
                end
            end
            S_L_DN, S_L_UP: begin
                if (r_state == S_L_DN && w_down) begin
                    n_ri    = r_ri - RI_W'(1);
                    w_re    = 1'b1;
                    w_raddr = r_ri - RI_W'(1);
                end else if (w_up) begin
                    n_ri    = r_ri + RI_W'(1);
                    w_re    = 1'b1;
                    w_raddr = r_ri + RI_W'(1);
                    n_state = S_L_UP;
                end else begin
                    n_off   = r_index - w_q.first;
                    n_last  = r_ri;
                    n_state = S_L_MUL;
                end
            end
            S_L_MUL: begin
                n_pprod = 32'(r_off) * 32'(pwrt_pkg::PACKET_BYTES);
                n_mprod = 32'(r_off) * 32'(pwrt_pkg::META_BYTES);
                n_state = S_L_ADD;
            end
            S_L_ADD: begin
                n_paddr      = w_paddr;
                n_maddr      = w_q.mbase + r_mprod;
                w_slot_start = 1'b1;
                n_state      = S_L_SLOT;
            end
            S_L_SLOT: begin
                if (w_slot_done) begin
                    n_slot   = w_slot_res.slot;
                    n_svalid = w_slot_res.valid;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pa     = r_paddr;
                    n_out_ma     = r_maddr;
                    n_out_slot   = r_slot;
                    n_out_sv     = r_svalid;
                    n_out_ws     = r_total;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_total     <= '0;
            r_last      <= '0;
            r_ri        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_total     <= n_total;
            r_last      <= n_last;
            r_ri        <= n_ri;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index      <= n_index;
        r_count      <= n_count;
        r_pb         <= n_pb;
        r_mb         <= n_mb;
        r_buf        <= n_buf;
        r_slots      <= n_slots;
        r_off        <= n_off;
        r_pprod      <= n_pprod;
        r_mprod      <= n_mprod;
        r_status     <= n_status;
        r_paddr      <= n_paddr;
        r_maddr      <= n_maddr;
        r_slot       <= n_slot;
        r_svalid     <= n_svalid;
        r_out_status <= n_out_status;
        r_out_pa     <= n_out_pa;
        r_out_ma     <= n_out_ma;
        r_out_slot   <= n_out_slot;
        r_out_sv     <= n_out_sv;
        r_out_ws     <= n_out_ws;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {7'b0, r_out_ws, r_out_sv, r_out_slot, r_out_ma, r_out_pa};

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UC_W'(pwrt_pkg::MAX_RANGES))
        else $error("range count exceeds the table depth");

    a_last_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) || (UC_W'(r_last) < r_used))
        else $error("last range used points beyond the ranges in use");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE || r_state == S_A_CMP))
        else $error("table written outside an append");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || i_m_axis_tready))
        |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not moved to the output register");

    a_slot_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slot_done |-> (r_state == S_L_SLOT))
        else $error("slot result arrived outside a lookup");

endmodule
